// ===== rtl/core/irn_pkg.sv =====
// Shared types, sizes and the sine table for the nearest-neighbor image rotator.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package irn_pkg;

	// Frame store and coordinate sizes
	localparam int unsigned MAX_DIM     = 512;
	localparam int unsigned COORD_W     = $clog2(MAX_DIM);
	localparam int unsigned ADDR_W      = 2 * COORD_W;
	localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned LIM_W       = COORD_W + 1;

	// Field widths
	localparam int unsigned CFG_W   = 10;
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Fixed-point trig sizes
	localparam int unsigned TRIG_FRAC_BITS = 15;
	localparam int unsigned TRIG_Q         = 30;
	localparam int unsigned MAG_W          = TRIG_FRAC_BITS + 1;
	localparam int unsigned TRIG_W         = TRIG_FRAC_BITS + 2;
	localparam int unsigned OFS_W          = CFG_W + 1;
	localparam int unsigned PROD_W         = OFS_W + TRIG_W;
	localparam int unsigned ACC_W          = PROD_W + 2;
	localparam int unsigned IDX_W          = ACC_W - TRIG_FRAC_BITS;
	localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_OUT_SIZE   = 2'd2,
		REG_ANGLE_DEG  = 2'd3
	} irn_reg_t;

	// Request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic [CFG_W-1:0]        col;
		logic [CFG_W-1:0]        row;
		logic signed [PIX_W-1:0] pixel_in;
	} irn_req_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_out;
		logic                    inside_res;
	} irn_rsp_t;

	// Image geometry from the register file
	typedef struct packed {
		logic [CFG_W-1:0] src_width;
		logic [CFG_W-1:0] src_height;
		logic [CFG_W-1:0] out_size;
	} irn_geom_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} irn_trig_t;

	// One frame store access from the mapper
	typedef struct packed {
		logic                    wr;
		logic                    rd;
		logic                    in_bounds;
		logic [ADDR_W-1:0]       addr;
		logic signed [PIX_W-1:0] wdata;
	} irn_mem_req_t;

	typedef logic [90:0][MAG_W-1:0] sin_tab_t;

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << (TRIG_Q - 1))) >> TRIG_Q;
	endfunction

	function automatic logic [MAG_W-1:0] to_frac(input logic [63:0] v);
		logic [63:0] t;
		t = (v + (64'd1 << (TRIG_Q - TRIG_FRAC_BITS - 1))) >> (TRIG_Q - TRIG_FRAC_BITS);
		return t[MAG_W-1:0];
	endfunction

	// Sine of 0..90 degrees; Taylor sums in Q30, rounded to TRIG_FRAC_BITS
	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] pi30;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ts;
		logic [63:0] tc;
		logic [63:0] s;
		logic [63:0] c;
		tab  = '0;
		pi30 = (PI_Q60 + (64'd1 << 29)) >> 30;
		for (int k = 0; k <= 45; k++) begin
			x  = (64'(k) * pi30 + 64'd90) / 64'd180;
			x2 = qmul(x, x);
			ts = qmul(x, x2) / 64'd6;
			s  = x - ts;
			ts = qmul(ts, x2) / 64'd20;
			s  = s + ts;
			ts = qmul(ts, x2) / 64'd42;
			s  = s - ts;
			ts = qmul(ts, x2) / 64'd72;
			s  = s + ts;
			ts = qmul(ts, x2) / 64'd110;
			s  = s - ts;
			ts = qmul(ts, x2) / 64'd156;
			s  = s + ts;
			tc = qmul(64'd1 << TRIG_Q, x2) / 64'd2;
			c  = (64'd1 << TRIG_Q) - tc;
			tc = qmul(tc, x2) / 64'd12;
			c  = c + tc;
			tc = qmul(tc, x2) / 64'd30;
			c  = c - tc;
			tc = qmul(tc, x2) / 64'd56;
			c  = c + tc;
			tc = qmul(tc, x2) / 64'd90;
			c  = c - tc;
			tc = qmul(tc, x2) / 64'd132;
			c  = c + tc;
			tab[k] = to_frac(s);
			if (k < 45) begin
				tab[90 - k] = to_frac(c);
			end
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// ===== rtl/core/irn_trig.sv =====
// Sine and cosine of the configured angle, reduced to 0..359 and looked up per quadrant.
// Depends on irn_pkg for the sine table and trig types.
`timescale 1ns / 1ps

module irn_trig
	import irn_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [CFG_W-1:0] angle_deg,
	output irn_trig_t               trig
);

	logic signed [CFG_W:0] angle_ext;
	logic [CFG_W:0]        wrap_sum;
	logic [CFG_W-1:0]      d_pos;
	logic [8:0]            d_mod;
	logic [1:0]            quad;
	logic [8:0]            quad_base;
	logic [6:0]            rem_deg;
	logic [6:0]            rem_inv;
	logic [MAG_W-1:0]      mag_fwd;
	logic [MAG_W-1:0]      mag_inv;
	logic signed [TRIG_W-1:0] pos_fwd;
	logic signed [TRIG_W-1:0] pos_inv;
	irn_trig_t             trig_d;

	// Bring the angle into 0..359 with a non-negative modulo
	always_comb begin
		angle_ext = {angle_deg[CFG_W-1], angle_deg};
		wrap_sum  = angle_ext + (CFG_W+1)'(720);
		d_pos     = angle_deg[CFG_W-1] ? wrap_sum[CFG_W-1:0] : angle_deg;
		d_mod     = (d_pos >= CFG_W'(360)) ? 9'(d_pos - CFG_W'(360)) : d_pos[8:0];
	end

	// Split into quadrant and remainder degrees
	always_comb begin
		if (d_mod < 9'd90) begin
			quad      = 2'd0;
			quad_base = 9'd0;
		end else if (d_mod < 9'd180) begin
			quad      = 2'd1;
			quad_base = 9'd90;
		end else if (d_mod < 9'd270) begin
			quad      = 2'd2;
			quad_base = 9'd180;
		end else begin
			quad      = 2'd3;
			quad_base = 9'd270;
		end
		rem_deg = 7'(d_mod - quad_base);
		rem_inv = 7'd90 - rem_deg;
		mag_fwd = SIN_TAB[rem_deg];
		mag_inv = SIN_TAB[rem_inv];
		pos_fwd = $signed({1'b0, mag_fwd});
		pos_inv = $signed({1'b0, mag_inv});
	end

	// Quadrant symmetry; cosine is the sine one quadrant on
	always_comb begin
		case (quad)
			2'd0: begin
				trig_d.sin_v = pos_fwd;
				trig_d.cos_v = pos_inv;
			end
			2'd1: begin
				trig_d.sin_v = pos_inv;
				trig_d.cos_v = -pos_fwd;
			end
			2'd2: begin
				trig_d.sin_v = -pos_fwd;
				trig_d.cos_v = -pos_inv;
			end
			2'd3: begin
				trig_d.sin_v = -pos_inv;
				trig_d.cos_v = pos_fwd;
			end
			default: begin
				trig_d.sin_v = pos_fwd;
				trig_d.cos_v = pos_inv;
			end
		endcase
	end

	// Hold the coefficients; they follow the angle register in the cycle after it changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig.sin_v <= '0;
			trig.cos_v <= TRIG_W'(1) <<< TRIG_FRAC_BITS;
		end else begin
			trig <= trig_d;
		end
	end

endmodule

// ===== rtl/core/irn_map.sv =====
// Inverse mapping: centers the output pixel, rotates it and checks the source bounds.
// Depends on irn_pkg; feeds one frame store access per cycle to irn_store.
`timescale 1ns / 1ps

module irn_map
	import irn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  irn_req_t     req_s1,
	input  irn_geom_t    geom,
	input  irn_trig_t    trig,
	output irn_mem_req_t mem_req
);

	logic [8:0]                hs;
	logic signed [OFS_W-1:0]   xx;
	logic signed [OFS_W-1:0]   yy;
	logic                      store_hit;

	logic                      valid_s2;
	logic                      op_s2;
	logic                      store_hit_s2;
	logic [ADDR_W-1:0]         waddr_s2;
	logic signed [PIX_W-1:0]   pix_s2;
	logic signed [PROD_W-1:0]  xc_s2;
	logic signed [PROD_W-1:0]  ys_s2;
	logic signed [PROD_W-1:0]  xs_s2;
	logic signed [PROD_W-1:0]  yc_s2;

	logic [8:0]                hx;
	logic [8:0]                hy;
	logic [LIM_W-1:0]          wl;
	logic [LIM_W-1:0]          hl;
	logic signed [ACC_W-1:0]   x_acc;
	logic signed [ACC_W-1:0]   y_acc;
	logic signed [ACC_W-1:0]   x_adj;
	logic signed [ACC_W-1:0]   y_adj;
	logic [IDX_W-1:0]          i_val;
	logic [IDX_W-1:0]          j_val;
	logic                      in_bounds;

	// Center the output coordinate on the output square
	always_comb begin
		hs = (geom.out_size == '0) ? 9'd0 : 9'((geom.out_size - CFG_W'(1)) >> 1);
		xx = $signed({1'b0, req_s1.col}) - $signed({2'b0, hs});
		yy = $signed({2'b0, hs}) - $signed({1'b0, req_s1.row});
		store_hit = (32'(req_s1.col) < MAX_DIM) && (32'(req_s1.row) < MAX_DIM);
	end

	// Register the four rotation products
	always_ff @(posedge clk) begin
		xc_s2        <= xx * trig.cos_v;
		ys_s2        <= yy * trig.sin_v;
		xs_s2        <= xx * trig.sin_v;
		yc_s2        <= yy * trig.cos_v;
		op_s2        <= req_s1.opcode;
		store_hit_s2 <= store_hit;
		waddr_s2     <= {req_s1.row[COORD_W-1:0], req_s1.col[COORD_W-1:0]};
		pix_s2       <= req_s1.pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Source center and store-limited bounds
	always_comb begin
		hx = (geom.src_width == '0) ? 9'd0 : 9'((geom.src_width - CFG_W'(1)) >> 1);
		hy = (geom.src_height == '0) ? 9'd0 : 9'((geom.src_height - CFG_W'(1)) >> 1);
		wl = (32'(geom.src_width) < MAX_DIM) ? LIM_W'(geom.src_width) : LIM_W'(MAX_DIM);
		hl = (32'(geom.src_height) < MAX_DIM) ? LIM_W'(geom.src_height) : LIM_W'(MAX_DIM);
	end

	// Sum, shift to the source center and truncate toward zero
	always_comb begin
		x_acc = ACC_W'(xc_s2) + ACC_W'(ys_s2)
			+ $signed(ACC_W'({hx, {TRIG_FRAC_BITS{1'b0}}}));
		y_acc = $signed(ACC_W'({hy, {TRIG_FRAC_BITS{1'b0}}}))
			+ ACC_W'(xs_s2) - ACC_W'(yc_s2);
		x_adj = x_acc + (x_acc[ACC_W-1] ? $signed(ACC_W'((1 << TRIG_FRAC_BITS) - 1)) : '0);
		y_adj = y_acc + (y_acc[ACC_W-1] ? $signed(ACC_W'((1 << TRIG_FRAC_BITS) - 1)) : '0);
		i_val = x_adj[ACC_W-1:TRIG_FRAC_BITS];
		j_val = y_adj[ACC_W-1:TRIG_FRAC_BITS];
		in_bounds = !i_val[IDX_W-1] && (i_val[IDX_W-2:0] < (IDX_W-1)'(wl))
			&& !j_val[IDX_W-1] && (j_val[IDX_W-2:0] < (IDX_W-1)'(hl));
	end

	// Issue the store access: write at the given place, or read the mapped pixel
	always_comb begin
		mem_req.wr        = valid_s2 && (op_s2 == OP_WRITE) && store_hit_s2;
		mem_req.rd        = valid_s2 && (op_s2 == OP_READ);
		mem_req.in_bounds = in_bounds;
		mem_req.addr      = (op_s2 == OP_WRITE) ? waddr_s2
			: {j_val[COORD_W-1:0], i_val[COORD_W-1:0]};
		mem_req.wdata     = pix_s2;
	end

endmodule

// ===== rtl/core/irn_store.sv =====
// Frame store with a registered read port, and the result register behind it.
// Depends on irn_pkg for sizes and the access struct.
`timescale 1ns / 1ps

module irn_store
	import irn_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  irn_mem_req_t mem_req,
	output logic         done,
	output irn_rsp_t     rsp
);

	logic signed [PIX_W-1:0] mem [0:STORE_DEPTH-1];
	logic signed [PIX_W-1:0] rdata_s3;
	logic                    inside_s3;
	logic                    rd_valid_s3;

	// One access per cycle, in request order
	always_ff @(posedge clk) begin
		if (mem_req.wr) begin
			mem[mem_req.addr] <= mem_req.wdata;
		end
		rdata_s3  <= mem[mem_req.addr];
		inside_s3 <= mem_req.in_bounds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s3 <= 1'b0;
		end else begin
			rd_valid_s3 <= mem_req.rd;
		end
	end

	// Drop the pixel when the source lies outside
	always_comb begin
		done           = rd_valid_s3;
		rsp.inside_res = inside_s3;
		rsp.pixel_out  = inside_s3 ? rdata_s3 : '0;
	end

endmodule

// ===== rtl/core/image_rotate_nearest_core.sv =====
// Nearest-neighbor image rotator: frame store writes and inverse-mapped pixel reads.
// A read request's result is strobed by done from the read register, behind the input and product registers.
// Throughput: one request per cycle, set by the single-port frame store; busy stays low.
// Reset (arst_n, async): registers return to 512 x 512 source, 726 output, angle 0;
// the frame store is not cleared. Results cannot be stalled. Uses irn_pkg and submodules.
`timescale 1ns / 1ps

module image_rotate_nearest_core
	import irn_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               start,
	output logic               busy,
	input  irn_req_t           req,
	// result channel
	output logic               done,
	output irn_rsp_t           rsp,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic                    accept;
	logic                    cfg_wr;
	irn_reg_t                reg_sel;
	irn_geom_t               geom_q;
	logic signed [CFG_W-1:0] angle_q;
	irn_trig_t               trig;
	logic                    valid_s1;
	irn_req_t                req_s1;
	irn_mem_req_t            mem_req;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	// Register file writes
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = irn_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.src_width  <= CFG_W'(512);
			geom_q.src_height <= CFG_W'(512);
			geom_q.out_size   <= CFG_W'(726);
			angle_q           <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_SRC_WIDTH:  geom_q.src_width  <= pwdata[CFG_W-1:0];
				REG_SRC_HEIGHT: geom_q.src_height <= pwdata[CFG_W-1:0];
				REG_OUT_SIZE:   geom_q.out_size   <= pwdata[CFG_W-1:0];
				REG_ANGLE_DEG:  angle_q           <= $signed(pwdata[CFG_W-1:0]);
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_sel)
			REG_SRC_WIDTH:  prdata = PDATA_W'(geom_q.src_width);
			REG_SRC_HEIGHT: prdata = PDATA_W'(geom_q.src_height);
			REG_OUT_SIZE:   prdata = PDATA_W'(geom_q.out_size);
			REG_ANGLE_DEG:  prdata = PDATA_W'(angle_q);
			default:        prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	irn_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_deg (angle_q),
		.trig      (trig)
	);

	irn_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.geom     (geom_q),
		.trig     (trig),
		.mem_req  (mem_req)
	);

	irn_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.done    (done),
		.rsp     (rsp)
	);

	// A read request yields a result on done once it has passed the pipeline registers
	a_read_result : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.opcode == OP_READ) |-> ##3 done)
		else $error("read request produced no result");

	// A write request yields no result
	a_write_silent : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.opcode == OP_WRITE) |-> ##3 !done)
		else $error("write request produced a result");

	// An outside result carries a zero pixel
	a_outside_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.inside_res) |-> (rsp.pixel_out == '0))
		else $error("outside result with nonzero pixel");

endmodule

// ===== test/image_rotate_nearest_core_tb.sv =====
// Testbench for image_rotate_nearest_core: stores source pixels, then reads rotated pixels and
// checks each one against a fixed-point inverse-mapping predictor kept in a scoreboard class.
// Depends on irn_pkg for the request, result and register index types.
`timescale 1ns / 1ps

module image_rotate_nearest_core_tb;
	import irn_pkg::*;

	localparam int unsigned    STORE_DIM   = 512;
	localparam int unsigned    FRAC        = 15;
	localparam longint unsigned PI_FIXED   = 64'h3243F6A8885A308D;
	localparam int unsigned    SETTLE      = 6;
	localparam int unsigned    STALL_LIMIT = 500;
	localparam int unsigned    PHASE_ITEMS = 28;

	// Predicts rotated pixels and holds the reads still waiting for their result
	class rotation_check;
		logic [CFG_W-1:0]        width_r;
		logic [CFG_W-1:0]        height_r;
		logic [CFG_W-1:0]        size_r;
		logic signed [CFG_W-1:0] angle_r;
		longint                  sine_q [91];
		logic signed [PIX_W-1:0] source_pixels [int unsigned];
		irn_rsp_t                pending_pixels [$];
		int unsigned             errors;

		function new();
			longint unsigned pi_q30;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned ts;
			longint unsigned tc;
			longint          sn;
			longint          cs;
			width_r  = 10'd512;
			height_r = 10'd512;
			size_r   = 10'd726;
			angle_r  = '0;
			errors   = 0;
			// Build sin(0..90 deg) from Taylor sums in Q30, then round to FRAC bits
			pi_q30 = (PI_FIXED + (64'd1 << 29)) >> 30;
			for (int k = 0; k <= 45; k++) begin
				x  = (longint'(k) * pi_q30 + 64'd90) / 64'd180;
				x2 = round_mul(x, x);
				ts = x;
				tc = 64'd1 << 30;
				sn = longint'(x);
				cs = longint'(tc);
				for (int n = 1; n <= 6; n++) begin
					ts = round_mul(ts, x2) / longint'((2 * n) * (2 * n + 1));
					tc = round_mul(tc, x2) / longint'((2 * n - 1) * (2 * n));
					if (n % 2 == 1) begin
						sn -= longint'(ts);
						cs -= longint'(tc);
					end else begin
						sn += longint'(ts);
						cs += longint'(tc);
					end
				end
				sine_q[k] = (sn + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
				if (k < 45)
					sine_q[90 - k] = (cs + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
			end
		endfunction

		function longint unsigned round_mul(longint unsigned a, longint unsigned b);
			return (a * b + (64'd1 << 29)) >> 30;
		endfunction

		function longint sine_at(int deg);
			int r;
			r = deg % 90;
			case ((deg / 90) % 4)
				0:       return sine_q[r];
				1:       return sine_q[90 - r];
				2:       return -sine_q[r];
				default: return -sine_q[90 - r];
			endcase
		endfunction

		function longint half_span(logic [CFG_W-1:0] v);
			return (v == 0) ? 0 : (longint'(v) - 1) / 2;
		endfunction

		function longint trunc_frac(longint a);
			return (a >= 0) ? (a >>> FRAC) : -((-a) >>> FRAC);
		endfunction

		function void set_reg(irn_reg_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_SRC_WIDTH:  width_r  = val;
				REG_SRC_HEIGHT: height_r = val;
				REG_OUT_SIZE:   size_r   = val;
				REG_ANGLE_DEG:  angle_r  = val;
				default: ;
			endcase
		endfunction

		// Map an output pixel back onto the source; return 1 when it lands inside
		function bit map_source(input logic [CFG_W-1:0] col, input logic [CFG_W-1:0] row,
				output int unsigned addr);
			int     deg;
			longint sv;
			longint cv;
			longint hs;
			longint xx;
			longint yy;
			longint px;
			longint py;
			longint ix;
			longint iy;
			longint wl;
			longint hl;
			deg  = ((int'(angle_r) % 360) + 360) % 360;
			sv   = sine_at(deg);
			cv   = sine_at((deg + 90) % 360);
			hs   = half_span(size_r);
			xx   = longint'(col) - hs;
			yy   = hs - longint'(row);
			px   = xx * cv + yy * sv;
			py   = -xx * sv + yy * cv;
			ix   = trunc_frac(px + (half_span(width_r) <<< FRAC));
			iy   = trunc_frac((half_span(height_r) <<< FRAC) - py);
			wl   = (width_r < STORE_DIM) ? longint'(width_r) : STORE_DIM;
			hl   = (height_r < STORE_DIM) ? longint'(height_r) : STORE_DIM;
			addr = 0;
			if (ix >= 0 && ix < wl && iy >= 0 && iy < hl) begin
				addr = int'(iy) * STORE_DIM + int'(ix);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// Apply an accepted request: store on write, queue the predicted pixel on read
		function void take_request(irn_req_t item);
			irn_rsp_t    want;
			int unsigned addr;
			if (item.opcode == OP_WRITE) begin
				if (item.col < STORE_DIM && item.row < STORE_DIM)
					source_pixels[item.row * STORE_DIM + item.col] = item.pixel_in;
				return;
			end
			want.inside_res = map_source(item.col, item.row, addr);
			want.pixel_out  = '0;
			if (want.inside_res && source_pixels.exists(addr))
				want.pixel_out = source_pixels[addr];
			pending_pixels.push_back(want);
		endfunction

		function void check_pixel(irn_rsp_t got);
			irn_rsp_t want;
			if (pending_pixels.size() == 0) begin
				$error("result with no read outstanding: pixel_out %0d inside_res %0b",
					got.pixel_out, got.inside_res);
				errors++;
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.inside_res !== want.inside_res) begin
				$error("inside_res: expected %0b, actual %0b", want.inside_res, got.inside_res);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic               busy;
	irn_req_t           req     = '0;
	logic               done;
	irn_rsp_t           rsp;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	rotation_check rot_check;
	bit            calm;

	image_rotate_nearest_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Check every strobed result against the oldest predicted pixel
	always @(posedge clk) begin
		if (arst_n && done)
			rot_check.check_pixel(rsp);
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Present one request, hold it until taken, then sometimes idle for a random gap
	task automatic issue(irn_req_t item);
		int unsigned gap;
		int unsigned pick;
		start <= 1'b1;
		req   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		rot_check.take_request(item);
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_pixel(logic [CFG_W-1:0] col, logic [CFG_W-1:0] row,
			logic [PIX_W-1:0] value);
		irn_req_t item;
		item.opcode   = OP_WRITE;
		item.col      = col;
		item.row      = row;
		item.pixel_in = value;
		issue(item);
	endtask

	// Read one output pixel; store its source pixel first if it was never written
	task automatic read_pixel(logic [CFG_W-1:0] col, logic [CFG_W-1:0] row);
		int unsigned addr;
		irn_req_t    item;
		if (rot_check.map_source(col, row, addr) && !rot_check.source_pixels.exists(addr))
			write_pixel(CFG_W'(addr % STORE_DIM), CFG_W'(addr / STORE_DIM), PIX_W'($urandom));
		item.opcode   = OP_READ;
		item.col      = col;
		item.row      = row;
		item.pixel_in = PIX_W'($urandom);
		issue(item);
	endtask

	// Stop requests, wait for every outstanding read, then let the pipeline empty
	task automatic drain();
		start <= 1'b0;
		while (rot_check.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(irn_reg_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {(PDATA_W - CFG_W)'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		rot_check.set_reg(idx, val);
	endtask

	task automatic set_geometry(int w, int h, int s, int a);
		drain();
		write_reg(REG_SRC_WIDTH, CFG_W'(w));
		write_reg(REG_SRC_HEIGHT, CFG_W'(h));
		write_reg(REG_OUT_SIZE, CFG_W'(s));
		write_reg(REG_ANGLE_DEG, CFG_W'(a));
	endtask

	// Random writes and reads under one geometry, mostly inside the output square
	task automatic run_phase(int w, int h, int s, int a);
		int unsigned span;
		int unsigned wspan;
		set_geometry(w, h, s, a);
		calm  = ($urandom_range(0, 3) == 0);
		span  = (s < 2) ? 1 : s;
		wspan = (w < 1) ? 1 : ((w > STORE_DIM) ? STORE_DIM : w);
		for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
			if ($urandom_range(0, 99) < 30) begin
				if ($urandom_range(0, 9) < 7)
					write_pixel(CFG_W'($urandom_range(0, wspan - 1)),
						CFG_W'($urandom_range(0, STORE_DIM - 1)), PIX_W'($urandom));
				else
					write_pixel(CFG_W'($urandom), CFG_W'($urandom), PIX_W'($urandom));
			end else if ($urandom_range(0, 9) == 0) begin
				read_pixel(CFG_W'($urandom), CFG_W'($urandom));
			end else begin
				read_pixel(CFG_W'($urandom_range(0, span - 1)),
					CFG_W'($urandom_range(0, span - 1)));
			end
		end
	endtask

	initial begin
		int geo [9][4] = '{
			'{1, 1, 2, -360},
			'{0, 5, 8, 45},
			'{7, 0, 0, 180},
			'{1023, 1023, 1023, 511},
			'{512, 512, 726, -512},
			'{16, 9, 19, 30},
			'{9, 16, 19, -135},
			'{40, 30, 51, 360},
			'{5, 5, 8, 270}
		};
		int w;
		int h;
		int s;
		rot_check = new();
		calm      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: corner pixels, ignored writes, reads at corners and past the output
		write_pixel(10'd0, 10'd0, 16'h8000);
		write_pixel(10'd511, 10'd511, 16'h7FFF);
		write_pixel(10'd1023, 10'd1023, 16'h5A5A);
		write_pixel(10'd512, 10'd3, 16'h1234);
		write_pixel(10'd7, 10'd600, 16'hFFFF);
		read_pixel(10'd362, 10'd362);
		read_pixel(10'd107, 10'd107);
		read_pixel(10'd618, 10'd618);
		read_pixel(10'd0, 10'd0);
		read_pixel(10'd725, 10'd725);
		read_pixel(10'd1023, 10'd0);
		read_pixel(10'd0, 10'd1023);

		// Tiny source turned a quarter turn
		set_geometry(3, 2, 4, 90);
		for (int r = 0; r < 2; r++)
			for (int c = 0; c < 4; c++)
				read_pixel(CFG_W'(c), CFG_W'(r));

		// Fixed geometries, zero and oversize among them, then random ones
		for (int p = 0; p < 9; p++)
			run_phase(geo[p][0], geo[p][1], geo[p][2], geo[p][3]);
		for (int p = 0; p < 4; p++) begin
			w = $urandom_range(1, 64);
			h = $urandom_range(1, 64);
			s = 0;
			while ((s + 1) * (s + 1) <= w * w + h * h)
				s++;
			run_phase(w, h, s + 1, int'($urandom_range(0, 720)) - 360);
		end

		drain();
		if (rot_check.errors == 0 && rot_check.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
